/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files; they compile to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Concurrent property checked at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

/* rtl/hdwt_pkg.sv */
// Constants shared by the Haar wavelet transform block.
`default_nettype none
package hdwt_pkg;
    localparam int MAX_LEN    = 64;
    localparam int ADDR_W     = $clog2(MAX_LEN);
    localparam int FILL_W     = ADDR_W + 1;
    localparam int LG_W       = 3;
    localparam logic [LG_W-1:0] MAX_LG = LG_W'(ADDR_W);

    localparam int DATA_W     = 32;
    localparam int OP_W       = DATA_W + 1;
    localparam int K_W        = 17;
    localparam int PROD_W     = OP_W + K_W;
    localparam int RND_W      = PROD_W + 1;
    localparam int FRAC_BITS  = 16;
    localparam logic signed [K_W-1:0]   HALF_ROOT_Q16 = 17'sd46341;
    localparam logic signed [RND_W-1:0] ROUND_BIAS    = RND_W'(32768);

    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;
    localparam logic [REG_IDX_W-1:0] REG_INVERSE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LENGTH  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LEVELS  = 2'd2;

    localparam logic [LG_W-1:0] LENGTH_RESET = 3'd6;
endpackage
`default_nettype wire

/* rtl/haar_dwt_1d_multilevel.sv */
// Multi-level 1-D Haar wavelet transform over a block of Q23.8 samples.
`default_nettype none
// The block collects 2^length_log2 samples (length clamped to 2..MAX_LEN),
// one per input transaction, then runs a forward or inverse orthonormal Haar
// transform of the configured depth in place and streams the block out with
// tlast on the final coefficient. Loading takes one cycle per sample. When
// the block completes the input side is held off through the transform and
// the emission, while a single shared add/multiply/round unit works through
// each level: for each butterfly pair a pass does one store read, one add,
// then multiply and write for the sum and again for the difference, and the
// pass ends by copying each entry of the scratch store back. Each coefficient
// is then read out through the registered read of the block store, and
// emission waits while the sink stalls. The last coefficient may still wait
// in the output register while loading of the next block begins. The stores
// need no clearing pass after reset.
// Registers on the APB port: inverse_mode at 0x0, length_log2 at 0x4 and
// level_count at 0x8 (0 or more than the length allows selects full depth);
// change them only while the block is idle.
module haar_dwt_1d_multilevel (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] sample_value
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] coef_value
    output logic             m_tlast,   // last_of_block
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [hdwt_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    `include "assert_macros.svh"

    localparam int AW = hdwt_pkg::ADDR_W;
    localparam int LW = hdwt_pkg::LG_W;
    localparam int DW = hdwt_pkg::DATA_W;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE = 4'd0;  // loading samples
    localparam logic [3:0] ST_RD   = 4'd1;  // read one butterfly pair
    localparam logic [3:0] ST_ADD  = 4'd2;  // form the sum
    localparam logic [3:0] ST_MUL  = 4'd3;  // scale by 1/sqrt2
    localparam logic [3:0] ST_WR   = 4'd4;  // round, saturate, write scratch
    localparam logic [3:0] ST_CRD  = 4'd5;  // read scratch for copy back
    localparam logic [3:0] ST_CWR  = 4'd6;  // write block store
    localparam logic [3:0] ST_ERD  = 4'd7;  // read a coefficient to emit
    localparam logic [3:0] ST_ELD  = 4'd8;  // hand it to the output register

    // Configuration registers.
    logic          inverse_reg;
    logic [LW-1:0] length_reg;
    logic [LW-1:0] levels_reg;

    // Control state.
    logic [3:0]                   state_reg, state_next;
    logic [hdwt_pkg::FILL_W-1:0]  fill_reg, fill_next;
    logic [AW-1:0]                pair_reg, pair_next;
    logic [AW-1:0]                copy_reg, copy_next;
    logic [AW-1:0]                emit_reg, emit_next;
    logic [LW-1:0]                pass_lg_reg, pass_lg_next;
    logic [LW-1:0]                passes_reg, passes_next;
    logic                         sel_reg, sel_next;
    logic                         out_valid_reg, out_valid_next;

    // Datapath registers.
    logic signed [hdwt_pkg::OP_W-1:0]   op_reg, op_next;
    logic signed [hdwt_pkg::PROD_W-1:0] prod_reg;
    logic [DW-1:0]                      out_data_reg, out_data_next;
    logic                               out_last_reg, out_last_next;
    logic [DW-1:0]                      rd_a_reg, rd_b_reg, scr_rd_reg;

    // Stores.
    logic [DW-1:0] block_mem   [hdwt_pkg::MAX_LEN];
    logic [DW-1:0] scratch_mem [hdwt_pkg::MAX_LEN];

    // Memory control.
    logic          blk_we, blk_rd_en, scr_we, scr_rd_en;
    logic [AW-1:0] blk_waddr, blk_addr_a, blk_addr_b, scr_waddr;
    logic [DW-1:0] blk_wdata, scr_wdata;

    // Derived values.
    logic [LW-1:0]               lg_eff, levels_eff;
    logic [hdwt_pkg::FILL_W-1:0] len_w;
    logic [AW-1:0]               len_m1, half, half_m1, n_m1;
    logic                        cfg_wr;
    logic [hdwt_pkg::REG_IDX_W-1:0] cfg_idx;

    // Rounding and saturation of the scaled product.
    logic signed [hdwt_pkg::RND_W-1:0]  rnd;
    logic signed [hdwt_pkg::RND_W-hdwt_pkg::FRAC_BITS-1:0] shifted;
    logic [DW-1:0]                      sat_val;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inverse_reg <= 1'b0;
            length_reg  <= hdwt_pkg::LENGTH_RESET;
            levels_reg  <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                hdwt_pkg::REG_INVERSE: inverse_reg <= pwdata[0];
                hdwt_pkg::REG_LENGTH:  length_reg  <= pwdata[LW-1:0];
                hdwt_pkg::REG_LEVELS:  levels_reg  <= pwdata[LW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            hdwt_pkg::REG_INVERSE: prdata = {31'b0, inverse_reg};
            hdwt_pkg::REG_LENGTH:  prdata = {29'b0, length_reg};
            hdwt_pkg::REG_LEVELS:  prdata = {29'b0, levels_reg};
            default:               prdata = '0;
        endcase
    end

    // Effective length and depth: the length clamps into the supported
    // range and a depth of zero, or beyond the length, means full depth.
    always_comb begin
        if (length_reg < LW'(1)) begin
            lg_eff = LW'(1);
        end else if (length_reg > hdwt_pkg::MAX_LG) begin
            lg_eff = hdwt_pkg::MAX_LG;
        end else begin
            lg_eff = length_reg;
        end
        if (levels_reg == '0 || levels_reg > lg_eff) begin
            levels_eff = lg_eff;
        end else begin
            levels_eff = levels_reg;
        end
    end

    assign len_w   = hdwt_pkg::FILL_W'(1) << lg_eff;
    assign len_m1  = AW'(len_w - hdwt_pkg::FILL_W'(1));
    assign half    = AW'(1) << (pass_lg_reg - LW'(1));
    assign half_m1 = half - AW'(1);
    assign n_m1    = (half << 1) - AW'(1);

    // ------------------------------------------------------------------
    // Shared scaling unit: (x * 46341 + 32768) >> 16 with floor, then
    // saturation to 32 bits.
    // ------------------------------------------------------------------
    assign rnd     = hdwt_pkg::RND_W'(prod_reg) + hdwt_pkg::ROUND_BIAS;
    assign shifted = rnd[hdwt_pkg::RND_W-1:hdwt_pkg::FRAC_BITS];

    always_comb begin
        if (shifted[$bits(shifted)-1:DW-1] == '0 ||
            shifted[$bits(shifted)-1:DW-1] == '1) begin
            sat_val = shifted[DW-1:0];
        end else if (shifted[$bits(shifted)-1]) begin
            sat_val = {1'b1, {(DW-1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(DW-1){1'b1}}};
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        pair_next      = pair_reg;
        copy_next      = copy_reg;
        emit_next      = emit_reg;
        pass_lg_next   = pass_lg_reg;
        passes_next    = passes_reg;
        sel_next       = sel_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        blk_we     = 1'b0;
        blk_waddr  = copy_reg;
        blk_wdata  = scr_rd_reg;
        blk_rd_en  = 1'b0;
        blk_addr_a = emit_reg;
        blk_addr_b = '0;
        scr_we     = 1'b0;
        scr_waddr  = '0;
        scr_wdata  = sat_val;
        scr_rd_en  = 1'b0;

        // The sink takes the waiting coefficient.
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    blk_we    = 1'b1;
                    blk_waddr = fill_reg[AW-1:0];
                    blk_wdata = s_tdata;
                    if (fill_reg + hdwt_pkg::FILL_W'(1) >= len_w) begin
                        fill_next   = '0;
                        pair_next   = '0;
                        passes_next = levels_eff;
                        if (inverse_reg) begin
                            pass_lg_next = lg_eff - levels_eff + LW'(1);
                        end else begin
                            pass_lg_next = lg_eff;
                        end
                        state_next = ST_RD;
                    end else begin
                        fill_next = fill_reg + hdwt_pkg::FILL_W'(1);
                    end
                end
            end
            ST_RD: begin
                blk_rd_en = 1'b1;
                if (inverse_reg) begin
                    blk_addr_a = pair_reg;
                    blk_addr_b = half + pair_reg;
                end else begin
                    blk_addr_a = pair_reg << 1;
                    blk_addr_b = (pair_reg << 1) | AW'(1);
                end
                state_next = ST_ADD;
            end
            ST_ADD: begin
                op_next    = $signed({rd_a_reg[DW-1], rd_a_reg})
                           + $signed({rd_b_reg[DW-1], rd_b_reg});
                sel_next   = 1'b0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_WR;
            end
            ST_WR: begin
                scr_we = 1'b1;
                if (inverse_reg) begin
                    scr_waddr = sel_reg ? ((pair_reg << 1) | AW'(1)) : (pair_reg << 1);
                end else begin
                    scr_waddr = sel_reg ? (half + pair_reg) : pair_reg;
                end
                if (!sel_reg) begin
                    op_next    = $signed({rd_a_reg[DW-1], rd_a_reg})
                               - $signed({rd_b_reg[DW-1], rd_b_reg});
                    sel_next   = 1'b1;
                    state_next = ST_MUL;
                end else if (pair_reg == half_m1) begin
                    copy_next  = '0;
                    state_next = ST_CRD;
                end else begin
                    pair_next  = pair_reg + AW'(1);
                    state_next = ST_RD;
                end
            end
            ST_CRD: begin
                scr_rd_en  = 1'b1;
                state_next = ST_CWR;
            end
            ST_CWR: begin
                blk_we = 1'b1;
                if (copy_reg == n_m1) begin
                    if (passes_reg == LW'(1)) begin
                        emit_next  = '0;
                        state_next = ST_ERD;
                    end else begin
                        passes_next = passes_reg - LW'(1);
                        pair_next   = '0;
                        if (inverse_reg) begin
                            pass_lg_next = pass_lg_reg + LW'(1);
                        end else begin
                            pass_lg_next = pass_lg_reg - LW'(1);
                        end
                        state_next = ST_RD;
                    end
                end else begin
                    copy_next  = copy_reg + AW'(1);
                    state_next = ST_CRD;
                end
            end
            ST_ERD: begin
                blk_rd_en  = 1'b1;
                state_next = ST_ELD;
            end
            ST_ELD: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd_a_reg;
                    out_last_next  = (emit_reg == len_m1);
                    if (emit_reg == len_m1) begin
                        state_next = ST_IDLE;
                    end else begin
                        emit_next  = emit_reg + AW'(1);
                        state_next = ST_ERD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            pair_reg      <= '0;
            copy_reg      <= '0;
            emit_reg      <= '0;
            pass_lg_reg   <= '0;
            passes_reg    <= '0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            pair_reg      <= pair_next;
            copy_reg      <= copy_next;
            emit_reg      <= emit_next;
            pass_lg_reg   <= pass_lg_next;
            passes_reg    <= passes_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        prod_reg     <= op_reg * hdwt_pkg::HALF_ROOT_Q16;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // ------------------------------------------------------------------
    // Stores: block store has one write and two registered reads, the
    // scratch store one write and one registered read.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (blk_we) begin
            block_mem[blk_waddr] <= blk_wdata;
        end
        if (blk_rd_en) begin
            rd_a_reg <= block_mem[blk_addr_a];
            rd_b_reg <= block_mem[blk_addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (scr_we) begin
            scratch_mem[scr_waddr] <= scr_wdata;
        end
        if (scr_rd_en) begin
            scr_rd_reg <= scratch_mem[copy_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_NEVER(fill_in_range, aclk, aresetn,
        fill_reg >= hdwt_pkg::FILL_W'(hdwt_pkg::MAX_LEN))
    `ASSERT_CLK(pass_setup_sane, aclk, aresetn,
        (state_reg == ST_RD) |-> (passes_reg != '0 && pass_lg_reg != '0 &&
        pass_lg_reg <= lg_eff))
    `ASSERT_CLK(scratch_write_in_pass, aclk, aresetn,
        scr_we |-> (scr_waddr <= n_m1))
    `ASSERT_CLK(emit_follows_copy, aclk, aresetn,
        (state_reg == ST_ERD && $past(state_reg) == ST_CWR) |-> (emit_reg == '0))

endmodule
`default_nettype wire
